// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the free slot search.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/ffs_pkg.sv =====
// Types and constants of the free slot search.
// No dependencies; used by every module of the block.
package ffs_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int TIME_W        = 10;
  localparam int END_W         = TIME_W + 1;
  localparam int SUM_W         = TIME_W + 2;

  localparam logic [TIME_W-1:0] DEFAULT_HORIZON = TIME_W'(30);

  // Request kinds carried in in_tuser.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Configuration register indexes.
  typedef enum logic {
    REG_REQUIRED_LENGTH = 1'b0,
    REG_HORIZON         = 1'b1
  } reg_idx_t;

  // One busy interval held in a cell.
  typedef struct packed {
    logic [TIME_W-1:0] length;
    logic [TIME_W-1:0] start;
  } entry_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_cmd_t;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } srch_state_t;

  // Control from the search sequencer to the chain and top level.
  typedef struct packed {
    cell_cmd_t cmd;
    logic      commit;
  } srch_ctrl_t;

endpackage

// ===== rtl/core/first_fit_free_slot_search.sv =====
// First-fit free slot search. Add requests (in_tuser = 0) are taken one per
// cycle while no search runs: every cell of a 32-entry chain compares its
// start with the new one and either keeps its interval, takes its left
// neighbor's, or takes the new one, so the chain stays sorted with equal
// starts in arrival order. A full chain drops the interval and raises
// overflow for the next result. A finish request (in_tuser = 1) starts a
// walk that shifts the chain one entry per cycle toward cell 0, where the
// gap to the previous end is checked; the result then waits for the output
// register, and no request is accepted during the walk or that wait. The
// finish request clears the chain and the overflow flag.
// Depends on ffs_pkg, ffs_cell, ffs_search and assert_macros.svh.
`include "assert_macros.svh"
module first_fit_free_slot_search
  import ffs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Interval and finish requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] interval_start, [19:10] interval_length
  input  logic        in_tuser,   // [0] op
  // Search results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] slot_start, [11] overflow
  output logic        out_tuser,  // [0] found
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [TIME_W-1:0] need_r, need_nxt;
  logic [TIME_W-1:0] horizon_r, horizon_nxt;
  logic              dropped_r, dropped_nxt;

  entry_t               new_entry;
  entry_t               cell_entry [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] cell_valid;
  logic [MAX_INTERVALS-1:0] cell_gt;
  logic                 in_acc;
  logic                 add_acc;
  logic                 full;
  logic                 busy;
  cell_cmd_t            cell_cmd;
  srch_ctrl_t           ctrl;
  logic                 res_found;
  logic [END_W-1:0]     res_slot;
  logic                 res_ovf;

  assign new_entry = '{length: in_tdata[19:10], start: in_tdata[9:0]};
  assign in_acc    = in_tvalid && in_tready;
  assign add_acc   = in_acc && (in_tuser == OP_ADD);
  assign full      = cell_valid[MAX_INTERVALS-1];
  assign in_tready = !busy;
  assign cfg_ready = 1'b1;

  // Inserts come from the input; everything else from the sequencer.
  assign cell_cmd = (add_acc && !full) ? CELL_INSERT : ctrl.cmd;

  // Configuration registers.
  always_comb begin
    need_nxt    = need_r;
    horizon_nxt = horizon_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_REQUIRED_LENGTH: need_nxt    = cfg_data;
        REG_HORIZON:         horizon_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Overflow flag: set by an add to a full chain, cleared by the result.
  always_comb begin
    dropped_nxt = dropped_r;
    if (ctrl.commit) begin
      dropped_nxt = 1'b0;
    end else if (add_acc && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r    <= '0;
      horizon_r <= DEFAULT_HORIZON;
      dropped_r <= 1'b0;
    end else begin
      need_r    <= need_nxt;
      horizon_r <= horizon_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The cell chain.
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_g, left_v, right_v;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
      assign left_v = 1'b1;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_g = cell_gt[i-1];
      assign left_v = cell_valid[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end

    ffs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cell_cmd),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .left_valid  (left_v),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Gap search at the head of the chain.
  ffs_search u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_search (in_acc && (in_tuser == OP_FINISH)),
    .head_entry   (cell_entry[0]),
    .head_valid   (cell_valid[0]),
    .need         (need_r),
    .horizon      (horizon_r),
    .dropped      (dropped_r),
    .out_tready   (out_tready),
    .busy         (busy),
    .ctrl         (ctrl),
    .out_tvalid   (out_tvalid),
    .out_found    (res_found),
    .out_slot     (res_slot),
    .out_overflow (res_ovf)
  );

  assign out_tdata = {4'b0000, res_ovf, res_slot};
  assign out_tuser = res_found;

  // Occupied cells always form an unbroken run from cell 0.
  `ASSERT_NEVER(a_valid_prefix, clk, rst_n, (cell_valid & (cell_valid + 1'b1)) != '0, "gap in occupied cells")
  // An add to a full chain raises the overflow flag.
  `ASSERT_AT(a_full_drops, clk, rst_n, (add_acc && full) |=> dropped_r, "dropped add not flagged")

endmodule

// ===== rtl/core/ffs_cell.sv =====
// One cell of the sorted interval chain.
// Depends on ffs_pkg for the entry and command types.
module ffs_cell
  import ffs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_gt,
  input  logic      left_valid,
  input  entry_t    right_entry,
  input  logic      right_valid,
  output entry_t    entry,
  output logic      valid,
  output logic      gt
);

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   take_in;

  // This cell holds a later start than the interval being inserted.
  assign gt = valid_r && (entry_r.start > new_entry.start);

  // A cell moves on insert if it sorts after the new interval, or if it is
  // the first empty cell of the chain.
  assign take_in = gt || (!valid_r && left_valid);

  // Next contents of the cell.
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (cmd)
      CELL_INSERT: begin
        if (take_in) begin
          entry_nxt = left_gt ? left_entry : new_entry;
          valid_nxt = 1'b1;
        end
      end
      CELL_SHIFT: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

// ===== rtl/core/ffs_search.sv =====
// Search sequencer: walks the chain head, finds the first fitting gap and
// holds the result register. Depends on ffs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffs_search
  import ffs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_search,
  input  entry_t            head_entry,
  input  logic              head_valid,
  input  logic [TIME_W-1:0] need,
  input  logic [TIME_W-1:0] horizon,
  input  logic              dropped,
  input  logic              out_tready,
  output logic              busy,
  output srch_ctrl_t        ctrl,
  output logic              out_tvalid,
  output logic              out_found,
  output logic [END_W-1:0]  out_slot,
  output logic              out_overflow
);

  srch_state_t      state_r, state_nxt;
  logic             first_r, first_nxt;
  logic [END_W-1:0] prev_end_r, prev_end_nxt;
  logic             res_found_r, res_found_nxt;
  logic [END_W-1:0] res_slot_r, res_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [END_W-1:0] out_slot_r, out_slot_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [SUM_W-1:0] thresh;
  logic [END_W-1:0] head_end;
  logic             head_fits;
  logic             tail_fits;
  logic             walk_done;
  logic             out_free;

  // A gap fits when the next start reaches the previous end plus the need.
  // The previous end is zero before the first entry, which covers the
  // check of the first start against the required length.
  assign thresh    = {1'b0, prev_end_r} + {2'b00, need};
  assign head_end  = {1'b0, head_entry.start} + {1'b0, head_entry.length};
  assign head_fits = head_valid && ({2'b00, head_entry.start} >= thresh);
  assign tail_fits = {2'b00, horizon} >= thresh;
  assign walk_done = head_fits || !head_valid;
  assign out_free  = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start_search) state_nxt = ST_SEARCH;
      ST_SEARCH: if (walk_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Chain control.
  always_comb begin
    ctrl = '{cmd: CELL_HOLD, commit: 1'b0};
    unique case (state_r)
      ST_SEARCH: if (!walk_done) ctrl.cmd = CELL_SHIFT;
      ST_DONE: begin
        if (out_free) begin
          ctrl.cmd    = CELL_CLEAR;
          ctrl.commit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Walk registers and the pending result.
  always_comb begin
    first_nxt     = first_r;
    prev_end_nxt  = prev_end_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    if (start_search && state_r == ST_IDLE) begin
      first_nxt    = 1'b1;
      prev_end_nxt = '0;
    end else if (state_r == ST_SEARCH) begin
      if (walk_done) begin
        // An empty table always fits at zero; past the last entry the gap
        // runs up to the horizon.
        res_found_nxt = head_valid || first_r || tail_fits;
        res_slot_nxt  = (head_valid || first_r || tail_fits) ? prev_end_r : '0;
      end else begin
        first_nxt    = 1'b0;
        prev_end_nxt = head_end;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_ovf_nxt   = out_ovf_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_slot_nxt  = res_slot_r;
      out_ovf_nxt   = dropped;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    prev_end_r  <= prev_end_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_found    = out_found_r;
  assign out_slot     = out_slot_r;
  assign out_overflow = out_ovf_r;

  // A miss never reports a slot start.
  `ASSERT_NEVER(a_miss_slot_zero, clk, rst_n, out_valid_r && !out_found_r && (out_slot_r != '0), "miss with nonzero slot")
  // The chain only shifts while a real entry sits at its head.
  `ASSERT_AT(a_shift_needs_head, clk, rst_n, (ctrl.cmd == CELL_SHIFT) |-> (head_valid && state_r == ST_SEARCH), "shift without head entry")
  // A committed result shows up on the output and frees the sequencer.
  `ASSERT_AT(a_commit_shows, clk, rst_n, ctrl.commit |=> (out_valid_r && state_r == ST_IDLE), "commit did not reach output")

endmodule

// ===== sim/ffs_slot_checker.sv =====
`timescale 1ns / 100ps
// Checker for the first-fit free slot search: watches the request, result and
// configuration channels, predicts each search result and compares it.
// Depends on ffs_pkg; instantiated by first_fit_free_slot_search_tb.
module ffs_slot_checker
  import ffs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen,
  output int          slots_found,
  output int          overflows_seen
);

  typedef struct packed {
    logic             found;
    logic [END_W-1:0] slot;
    logic             overflow;
  } search_result_t;

  // Shadow copy of the busy table, the overflow flag and the registers.
  logic [TIME_W-1:0] busy_start [MAX_INTERVALS];
  logic [TIME_W-1:0] busy_len   [MAX_INTERVALS];
  int                busy_count;
  logic              dropped;
  logic [TIME_W-1:0] need_len;
  logic [TIME_W-1:0] window_end;

  search_result_t    expected_results [$];
  int                errors;
  int                n_results;
  int                n_found;
  int                n_overflow;

  // Sorted insertion; equal starts go after the ones already held.
  task automatic insert_busy(input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] len);
    int pos;
    if (busy_count >= MAX_INTERVALS) begin
      dropped = 1'b1;
      return;
    end
    pos = busy_count;
    while (pos > 0 && busy_start[pos-1] > start) begin
      busy_start[pos] = busy_start[pos-1];
      busy_len[pos]   = busy_len[pos-1];
      pos--;
    end
    busy_start[pos] = start;
    busy_len[pos]   = len;
    busy_count++;
  endtask

  // First gap of at least need_len between neighbors, then up to the horizon.
  // Gaps are signed, so overlaps and intervals past the horizon never fit.
  function automatic search_result_t first_fit_slot();
    search_result_t res;
    int             gap_end;
    res.found    = 1'b1;
    res.slot     = '0;
    res.overflow = dropped;
    if (busy_count == 0 || int'(busy_start[0]) >= int'(need_len))
      return res;
    for (int i = 0; i + 1 < busy_count; i++) begin
      gap_end = int'(busy_start[i]) + int'(busy_len[i]);
      if (int'(busy_start[i+1]) - gap_end >= int'(need_len)) begin
        res.slot = END_W'(gap_end);
        return res;
      end
    end
    gap_end = int'(busy_start[busy_count-1]) + int'(busy_len[busy_count-1]);
    if (int'(window_end) - gap_end >= int'(need_len))
      res.slot = END_W'(gap_end);
    else
      res.found = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int expected, input int actual);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
    errors++;
  endtask

  always @(posedge clk) begin
    search_result_t exp_res;
    if (!rst_n) begin
      busy_count = 0;
      dropped    = 1'b0;
      need_len   = '0;
      window_end = DEFAULT_HORIZON;
      expected_results.delete();
      errors     = 0;
      n_results  = 0;
      n_found    = 0;
      n_overflow = 0;
    end else begin
      // Results are checked first so a new expectation never meets an old result.
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, found %0b slot %0d overflow %0b", $time,
                   out_tuser, out_tdata[10:0], out_tdata[11]);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.found) n_found++;
          if (exp_res.overflow) n_overflow++;
          if (out_tuser !== exp_res.found)
            report_mismatch("found", exp_res.found, out_tuser);
          if (out_tdata[10:0] !== exp_res.slot)
            report_mismatch("slot_start", exp_res.slot, out_tdata[10:0]);
          if (out_tdata[11] !== exp_res.overflow)
            report_mismatch("overflow", exp_res.overflow, out_tdata[11]);
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_REQUIRED_LENGTH: need_len = cfg_data;
          REG_HORIZON:         window_end = cfg_data;
          default: ;
        endcase
      end
      // Accepted requests: add an interval, or search and clear the table.
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_FINISH) begin
          expected_results.push_back(first_fit_slot());
          busy_count = 0;
          dropped    = 1'b0;
        end else begin
          insert_busy(in_tdata[9:0], in_tdata[19:10]);
        end
      end
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
    results_seen    <= n_results;
    slots_found     <= n_found;
    overflows_seen  <= n_overflow;
  end

endmodule

// ===== sim/first_fit_free_slot_search_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the first-fit free slot search: directed and random
// interval sets under several settings, with random idling on both sides.
// Depends on ffs_pkg, first_fit_free_slot_search and ffs_slot_checker.
module first_fit_free_slot_search_tb;
  import ffs_pkg::*;

  localparam int SETTLE_CYCLES   = MAX_INTERVALS + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_REQUESTS  = 130;
  localparam int RANDOM_PHASES   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [9:0] interval_start, [19:10] interval_length
  logic        in_tuser = 1'b0; // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [10:0] slot_start, [11] overflow
  logic        out_tuser;       // [0] found
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [9:0]  cfg_data = '0;

  int fail_count;
  int pending_results;
  int results_seen;
  int slots_found;
  int overflows_seen;

  int requests_sent;
  int finishes_sent;
  int settings_written;
  bit tx_steady;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_fit_free_slot_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ffs_slot_checker slot_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .slots_found     (slots_found),
    .overflows_seen  (overflows_seen)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until accepted, then maybe idle.
  task automatic send_request(input logic op, input logic [9:0] start, input logic [9:0] len);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, len, start};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (op == OP_FINISH) finishes_sent++;
    gap = idle_cycles(tx_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_finish();
    send_request(OP_FINISH, 10'($urandom), 10'($urandom));
  endtask

  // Stop offering and wait until every search result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [9:0] need, input logic [9:0] window);
    drain_results();
    write_register(REG_REQUIRED_LENGTH, need);
    write_register(REG_HORIZON, window);
    settings_written++;
  endtask

  // One interval set followed by its finish request. Most intervals sit inside
  // the window with short lengths; the rest use the full field range.
  task automatic send_interval_set(input int window, output int sent);
    int n_adds;
    int start;
    int len;
    n_adds = ($urandom_range(0, 99) < 6) ? $urandom_range(31, 40) : $urandom_range(0, 7);
    for (int i = 0; i < n_adds; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        start = $urandom_range(0, window);
        len   = $urandom_range(0, window / 4 + 1);
      end else begin
        start = $urandom_range(0, 1023);
        len   = $urandom_range(0, 1023);
      end
      send_request(OP_ADD, 10'(start), 10'(len));
    end
    send_finish();
    sent = n_adds + 1;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    bit steady;
    bit held;
    int stall;
    steady = 1'b0;
    held   = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (rst_n && !held && results_seen >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        stall = idle_cycles(1'b0);
        if (stall == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_count;
    int sent;
    int need;
    int window;
    requests_sent    = 0;
    finishes_sent    = 0;
    settings_written = 0;
    tx_steady        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table under reset settings.
    send_finish();
    apply_setting(10'd5, 10'd30);
    // First interval starts late enough.
    send_request(OP_ADD, 10'd10, 10'd3);
    send_finish();
    // Gap found between neighbors after a too-short one.
    send_request(OP_ADD, 10'd20, 10'd5);
    send_request(OP_ADD, 10'd0, 10'd4);
    send_request(OP_ADD, 10'd6, 10'd2);
    send_finish();
    // Overlapping neighbors are not merged.
    send_request(OP_ADD, 10'd0, 10'd10);
    send_request(OP_ADD, 10'd3, 10'd2);
    send_request(OP_ADD, 10'd12, 10'd1);
    send_finish();
    // Interval running past the horizon.
    send_request(OP_ADD, 10'd0, 10'd40);
    send_finish();
    // Equal starts keep arrival order.
    send_request(OP_ADD, 10'd2, 10'd3);
    send_request(OP_ADD, 10'd2, 10'd10);
    send_finish();
    // Field and register extremes.
    apply_setting(10'd1023, 10'd1023);
    send_request(OP_ADD, 10'd1023, 10'd1023);
    send_finish();
    send_request(OP_ADD, 10'd0, 10'd1023);
    send_finish();

    // Random phases, each under its own setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin need = 0;    window = 0;    end
        1: begin need = 0;    window = 1023; end
        2: begin need = 1023; window = 0;    end
        3: begin need = 1023; window = 1023; end
        4: begin need = 0;    window = 30;   end
        5: begin need = $urandom_range(0, 1023); window = $urandom_range(0, 1023); end
        default: begin
          need   = $urandom_range(0, 20);
          window = $urandom_range(need, 200);
        end
      endcase
      apply_setting(10'(need), 10'(window));
      tx_steady   = ($urandom_range(0, 3) == 0);
      phase_count = 0;
      while (phase_count < PHASE_REQUESTS) begin
        send_interval_set(window, sent);
        phase_count += sent;
      end
    end

    drain_results();
    $display("Sent %0d requests (%0d searches) under %0d register settings.",
             requests_sent, finishes_sent, settings_written + 1);
    $display("Checked %0d results: %0d slots found, %0d with dropped intervals.",
             results_seen, slots_found, overflows_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Timeout at %0t with %0d results outstanding.", $time, pending_results);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ffs_pkg.sv
rtl/core/ffs_cell.sv
rtl/core/ffs_search.sv
rtl/core/first_fit_free_slot_search.sv
sim/ffs_slot_checker.sv
sim/first_fit_free_slot_search_tb.sv
